### src/lcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg
// shared constants and types of the longest common subsequence engine
// ----------------------------------------------------------------------------
package lcs_pkg;

	localparam int MAX_LEN_DEF = 1024;
	localparam int SYM_W       = 8;
	localparam int OUT_W       = 11;

	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_STREAM = 1'b1;

	// control part of the wavefront token moving along the cell chain
	typedef struct packed {
		logic valid;
		logic last;
	} tok_ctl_t;

endpackage

### src/lcs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_cell
// one column of the score row: holds a first-string symbol and its score,
// updates the score when a second-string token passes, hands the token on
// ----------------------------------------------------------------------------
module lcs_cell
	import lcs_pkg::*;
#(
	parameter int LW  = 11,
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ld,
	input  logic [SYM_W-1:0] ld_sym,
	input  tok_ctl_t         in_ctl,
	input  logic [SYM_W-1:0] in_sym,
	input  logic [LW-1:0]    in_len,
	input  logic [LW-1:0]    in_left,
	input  logic [LW-1:0]    in_diag,
	output tok_ctl_t         out_ctl,
	output logic [SYM_W-1:0] out_sym,
	output logic [LW-1:0]    out_len,
	output logic [LW-1:0]    out_left,
	output logic [LW-1:0]    out_diag
);

	logic [SYM_W-1:0] sym_q;
	logic [LW-1:0]    score_q;
	tok_ctl_t         ctl_q;
	logic [SYM_W-1:0] tsym_q;
	logic [LW-1:0]    len_q;
	logic [LW-1:0]    left_q;
	logic [LW-1:0]    diag_q;

	logic          active;
	logic [LW-1:0] v;

	// a token only counts columns that were loaded before it entered
	assign active = in_ctl.valid && (LW'(IDX) < in_len);

	always_comb begin
		if (sym_q == in_sym) begin
			v = in_diag + LW'(1);
		end else if (score_q > in_left) begin
			v = score_q;
		end else begin
			v = in_left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= in_ctl;
		end
	end

	always_ff @(posedge clk) begin
		tsym_q <= in_sym;
		len_q  <= in_len;
		left_q <= active ? v : in_left;
		diag_q <= active ? score_q : in_diag;
		if (ld) begin
			sym_q   <= ld_sym;
			score_q <= '0;
		end else if (active) begin
			// final symbol clears the row behind the wavefront
			score_q <= in_ctl.last ? '0 : v;
		end
	end

	assign out_ctl  = ctl_q;
	assign out_sym  = tsym_q;
	assign out_len  = len_q;
	assign out_left = left_q;
	assign out_diag = diag_q;

endmodule

### src/lcs_length_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_length_engine
// longest common subsequence length of two byte strings on a systolic row
// of cells, one cell per first-string symbol
// ----------------------------------------------------------------------------
// channel   direction  signals                     transfer
// item      in         mode, symbol, last          start high and busy low
// result    out        lcs_length, overflow        done high, one cycle
//
// a load item or a non-final stream item leaves busy low; stream symbols
// enter back to back as a wavefront along the MAX_LEN cell chain.
// after a final stream symbol busy stays high until the wavefront has left
// the chain, then done pulses once.
// reset clears the string length, the flag and all tokens in flight.
// the result is not held: the receiver takes it in the cycle of done.
// ----------------------------------------------------------------------------
module lcs_length_engine
	import lcs_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             mode,
	input  logic [SYM_W-1:0] symbol,
	input  logic             last,
	output logic             done,
	output logic [OUT_W-1:0] lcs_length,
	output logic             overflow
);

	localparam int LW = $clog2(MAX_LEN + 1);

	logic          accept;
	logic [LW-1:0] len_q;
	logic          ovf_q;
	logic          pend_q;
	logic          res_ovf_q;
	logic          done_q;
	logic [OUT_W-1:0] lcs_q;
	logic          ovf_out_q;

	tok_ctl_t         ctl_c  [MAX_LEN+1];
	logic [SYM_W-1:0] sym_c  [MAX_LEN+1];
	logic [LW-1:0]    len_c  [MAX_LEN+1];
	logic [LW-1:0]    left_c [MAX_LEN+1];
	logic [LW-1:0]    diag_c [MAX_LEN+1];

	tok_ctl_t         tok_ctl_q;
	logic [SYM_W-1:0] tok_sym_q;
	logic [LW-1:0]    tok_len_q;

	assign accept = start && !busy;
	assign busy   = pend_q;

	// entry register of the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ctl_q <= '0;
		end else begin
			tok_ctl_q.valid <= accept && (mode == MODE_STREAM);
			tok_ctl_q.last  <= accept && (mode == MODE_STREAM) && last;
		end
	end

	always_ff @(posedge clk) begin
		tok_sym_q <= symbol;
		tok_len_q <= len_q;
	end

	assign ctl_c[0]  = tok_ctl_q;
	assign sym_c[0]  = tok_sym_q;
	assign len_c[0]  = tok_len_q;
	assign left_c[0] = '0;
	assign diag_c[0] = '0;

	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		logic ld;
		assign ld = accept && (mode == MODE_LOAD) && (len_q == LW'(i));

		lcs_cell #(
			.LW  (LW),
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ld       (ld),
			.ld_sym   (symbol),
			.in_ctl   (ctl_c[i]),
			.in_sym   (sym_c[i]),
			.in_len   (len_c[i]),
			.in_left  (left_c[i]),
			.in_diag  (diag_c[i]),
			.out_ctl  (ctl_c[i+1]),
			.out_sym  (sym_c[i+1]),
			.out_len  (len_c[i+1]),
			.out_left (left_c[i+1]),
			.out_diag (diag_c[i+1])
		);
	end

	// string length, overflow flag and the wait for the final wavefront
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			ovf_q     <= 1'b0;
			pend_q    <= 1'b0;
			res_ovf_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= ctl_c[MAX_LEN].valid && ctl_c[MAX_LEN].last;
			if (ctl_c[MAX_LEN].valid && ctl_c[MAX_LEN].last) begin
				pend_q <= 1'b0;
			end
			if (accept) begin
				if (mode == MODE_LOAD) begin
					if (len_q < LW'(MAX_LEN)) begin
						len_q <= len_q + LW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end else if (last) begin
					len_q     <= '0;
					ovf_q     <= 1'b0;
					res_ovf_q <= ovf_q;
					pend_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		lcs_q     <= OUT_W'(left_c[MAX_LEN]);
		ovf_out_q <= res_ovf_q;
	end

	assign done       = done_q;
	assign lcs_length = lcs_q;
	assign overflow   = ovf_out_q;

endmodule

### dv/lcs_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_result_check
// watches the item and result channels of the lcs length engine, keeps its
// own copy of the first string and the score row, and compares every result
// with the length and flag worked out from the accepted items
// ----------------------------------------------------------------------------
module lcs_result_check
	import lcs_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic             mode,
	input  logic [SYM_W-1:0] symbol,
	input  logic             last,
	input  logic             done,
	input  logic [OUT_W-1:0] lcs_length,
	input  logic             overflow,
	output int               errors,
	output int               pending
);

	typedef struct {
		logic [OUT_W-1:0] len;
		logic             trunc;
	} lcs_result_t;

	logic [SYM_W-1:0] str_a [MAX_LEN];
	logic [OUT_W-1:0] dp_row [MAX_LEN];
	int               str_a_len;
	logic             trunc_seen;
	lcs_result_t      lcs_due [$];

	function automatic void clear_strings();
		for (int i = 0; i < MAX_LEN; i++) begin
			dp_row[i] = '0;
		end
		str_a_len  = 0;
		trunc_seen = 1'b0;
	endfunction

	// one wavefront step: diag is the old upper-left cell, left_new the new left cell
	function automatic void advance_row(input logic [SYM_W-1:0] c);
		logic [OUT_W-1:0] diag;
		logic [OUT_W-1:0] left_new;
		logic [OUT_W-1:0] up;
		logic [OUT_W-1:0] v;
		diag     = '0;
		left_new = '0;
		for (int i = 0; i < str_a_len; i++) begin
			up = dp_row[i];
			if (str_a[i] == c) begin
				v = diag + 1'b1;
			end else begin
				v = (up > left_new) ? up : left_new;
			end
			diag      = up;
			dp_row[i] = v;
			left_new  = v;
		end
	endfunction

	function automatic void absorb_item(input logic m, input logic [SYM_W-1:0] s,
			input logic fin);
		lcs_result_t r;
		if (m == MODE_LOAD) begin
			if (str_a_len < MAX_LEN) begin
				str_a[str_a_len] = s;
				str_a_len++;
			end else begin
				trunc_seen = 1'b1;
			end
		end else begin
			advance_row(s);
			if (fin) begin
				r.len   = (str_a_len > 0) ? dp_row[str_a_len-1] : '0;
				r.trunc = trunc_seen;
				lcs_due.push_back(r);
				clear_strings();
			end
		end
	endfunction

	function automatic void check_result();
		lcs_result_t r;
		if (lcs_due.size() == 0) begin
			$error("result transfer with none expected: lcs_length %0d overflow %0b",
				lcs_length, overflow);
			errors++;
		end else begin
			r = lcs_due.pop_front();
			if (lcs_length !== r.len) begin
				$error("lcs_length: expected %0d, actual %0d", r.len, lcs_length);
				errors++;
			end
			if (overflow !== r.trunc) begin
				$error("overflow: expected %0b, actual %0b", r.trunc, overflow);
				errors++;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_strings();
			lcs_due.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (done) begin
				check_result();
			end
			if (start && !busy) begin
				absorb_item(mode, symbol, last);
			end
			pending = lcs_due.size();
		end
	end

endmodule

### dv/tb_lcs_length_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcs_length_engine
// drives load and stream items into the lcs length engine in random bursts:
// a few hand-picked strings first, then random string pairs, noise and one
// pass past the store limit; a checker beside the block predicts each result
// ----------------------------------------------------------------------------
module tb_lcs_length_engine;
	import lcs_pkg::*;

	localparam int MAX_LEN    = MAX_LEN_DEF;
	localparam int RAND_ITEMS = 1950;
	localparam int MIN_FINALS = 45;
	localparam int MAX_GAP    = 20;
	localparam int STALL_CAP  = 4 * (MAX_LEN + 1 + MAX_GAP + 44);

	typedef struct packed {
		logic             mode;
		logic [SYM_W-1:0] sym;
		logic             last;
	} item_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             mode;
	logic [SYM_W-1:0] symbol;
	logic             last;
	logic             done;
	logic [OUT_W-1:0] lcs_length;
	logic             overflow;
	int               errors;
	int               pending;

	int               sent = 0;
	int               finals = 0;
	int               burst_left = 0;
	int               stall = 0;
	logic [SYM_W-1:0] loaded [$];

	always #4 clk = ~clk;

	lcs_length_engine #(.MAX_LEN(MAX_LEN)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .symbol(symbol), .last(last),
		.done(done), .lcs_length(lcs_length), .overflow(overflow)
	);

	lcs_result_check #(.MAX_LEN(MAX_LEN)) u_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .symbol(symbol), .last(last),
		.done(done), .lcs_length(lcs_length), .overflow(overflow),
		.errors(errors), .pending(pending)
	);

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall <= 0;
			end else if (stall >= STALL_CAP) begin
				$display("tb_lcs_length_engine: FAIL");
				$finish;
			end else begin
				stall <= stall + 1;
			end
		end
	end

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic push_item(input item_t it);
		if (burst_left == 0) begin
			idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP));
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		start  <= 1'b1;
		mode   <= it.mode;
		symbol <= it.sym;
		last   <= it.last;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
		if (it.mode == MODE_STREAM && it.last) begin
			finals++;
		end
	endtask

	task automatic load_sym(input logic [SYM_W-1:0] s, input logic fin);
		push_item('{mode: MODE_LOAD, sym: s, last: fin});
		loaded.push_back(s);
	endtask

	task automatic stream_sym(input logic [SYM_W-1:0] s, input logic fin);
		push_item('{mode: MODE_STREAM, sym: s, last: fin});
		if (fin) begin
			loaded.delete();
		end
	endtask

	// a string pair: loads, then streamed symbols drawn partly from the loads,
	// now and then a load slipped in after streaming began
	task automatic pair_sequence(input bit with_final);
		int               n_load;
		int               n_stream;
		int               span;
		bit               full;
		logic [SYM_W-1:0] base;
		logic [SYM_W-1:0] s;
		n_load   = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
		n_stream = $urandom_range(0, 12);
		full     = ($urandom_range(0, 3) == 0);
		span     = $urandom_range(0, 4);
		base     = SYM_W'($urandom_range(0, 255));
		repeat (n_load) begin
			s = full ? SYM_W'($urandom_range(0, 255)) : base + SYM_W'($urandom_range(0, span));
			load_sym(s, ($urandom_range(0, 7) == 0));
		end
		for (int i = 0; i <= n_stream; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				load_sym(base + SYM_W'($urandom_range(0, span)), 1'b0);
			end
			if (loaded.size() > 0 && $urandom_range(0, 1) == 1) begin
				s = loaded[$urandom_range(0, loaded.size() - 1)];
			end else begin
				s = full ? SYM_W'($urandom_range(0, 255)) : base + SYM_W'($urandom_range(0, span));
			end
			if (i < n_stream || with_final) begin
				stream_sym(s, (i == n_stream) && with_final);
			end
		end
	endtask

	task automatic noise_sequence();
		logic m;
		repeat ($urandom_range(1, 6)) begin
			m = 1'($urandom_range(0, 1));
			if (m == MODE_LOAD) begin
				load_sym(SYM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				stream_sym(SYM_W'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
			end
		end
	endtask

	// fills the store past its limit, then streams symbols picked in order from it, some of them random
	task automatic full_store_sequence();
		int idx;
		repeat (MAX_LEN + $urandom_range(1, 4)) begin
			load_sym(SYM_W'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
		end
		idx = 0;
		for (int i = 0; i < 40; i++) begin
			idx = idx + $urandom_range(0, 30);
			if (idx > MAX_LEN - 1) begin
				idx = MAX_LEN - 1;
			end
			stream_sym(($urandom_range(0, 3) == 0) ? SYM_W'($urandom_range(0, 255)) : loaded[idx],
				(i == 39));
		end
	endtask

	initial begin
		int kind;
		bit big_done;
		start    = 1'b0;
		mode     = MODE_LOAD;
		symbol   = '0;
		last     = 1'b0;
		arst_n   = 1'b0;
		big_done = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty first string
		stream_sym(8'h00, 1'b1);
		// both symbol extremes, last on a load is ignored
		load_sym(8'h00, 1'b0);
		load_sym(8'hFF, 1'b1);
		stream_sym(8'hFF, 1'b0);
		stream_sym(8'h00, 1'b0);
		stream_sym(8'hFF, 1'b1);
		// load after streaming began
		load_sym(8'h41, 1'b0);
		stream_sym(8'h42, 1'b0);
		load_sym(8'h42, 1'b0);
		stream_sym(8'h41, 1'b0);
		stream_sym(8'h42, 1'b1);
		// no matches at all
		load_sym(8'h55, 1'b0);
		load_sym(8'h55, 1'b0);
		load_sym(8'h55, 1'b0);
		stream_sym(8'hAA, 1'b0);
		stream_sym(8'hAA, 1'b1);
		// single symbol match
		load_sym(8'h7F, 1'b0);
		stream_sym(8'h7F, 1'b1);

		while (sent < RAND_ITEMS || finals < MIN_FINALS) begin
			if (!big_done && sent > 400) begin
				full_store_sequence();
				big_done = 1'b1;
			end
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				noise_sequence();
			end else if (kind == 1) begin
				pair_sequence(1'b0);
			end else begin
				pair_sequence(1'b1);
			end
		end
		// close any string left open so that nothing stays half done
		stream_sym(SYM_W'($urandom_range(0, 255)), 1'b1);
		@(negedge clk);
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (MAX_LEN + 16) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("tb_lcs_length_engine: PASS");
		end else begin
			$display("tb_lcs_length_engine: FAIL");
		end
		$finish;
	end

endmodule
